// File: design/aabb_overlap_penetration_assert.svh
// Assertion macros used by the checker file
`ifndef AABB_OVERLAP_PENETRATION_ASSERT_SVH
`define AABB_OVERLAP_PENETRATION_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AOP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aop assertion failed");

// next-cycle implication, disabled during reset
`define AOP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aop assertion failed");

`endif

// File: design/aop_pkg.sv
`default_nettype none

package aop_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int PIPE_STAGES    = 5;

    localparam logic [1:0] NRM_ZERO = 2'b00;
    localparam logic [1:0] NRM_POS  = 2'b01;
    localparam logic [1:0] NRM_NEG  = 2'b11;

    typedef struct packed {
        logic load_sum;
        logic load_half;
        logic load_diff;
        logic load_pen;
    } t_axis_en;

endpackage

`default_nettype wire

// File: design/aabb_overlap_penetration.sv
// Box-pair overlap test with minimum translation vector. One box pair enters per cycle
// while the pipeline is not stalled, and its result leaves through the output register
// after the five-stage pipeline (sums, halving, centre distance, penetration, axis select).
// Each stage holds while the one after it is full and stalled, so bubbles close up; a
// request is still taken while a finished result waits at the output if a stage is empty.
`default_nettype none

module aabb_overlap_penetration import aop_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // self_left, self_right, self_top, self_bottom,
    // other_left, other_right, other_top, other_bottom
    input  logic [((8*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // hit, delta_x, delta_y, normal_x, normal_y, position_x, position_y, zero fill
    output logic [((4*COORD_BITS+9+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int W        = COORD_BITS;
    localparam int OUT_USED = 4*W + 9;

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES:0]   rdy;
    t_axis_en               axis_en;

    logic signed [W+1:0] pen_x, pen_y;
    logic        [1:0]   nrm_x, nrm_y;
    logic signed [W-1:0] sc_x, sh_x, oc_x, sc_y, sh_y, oc_y;

    always_comb begin
        rdy[PIPE_STAGES] = i_m_axis_tready;
        for (int k = PIPE_STAGES-1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign axis_en.load_sum  = rdy[0];
    assign axis_en.load_half = rdy[1];
    assign axis_en.load_diff = rdy[2];
    assign axis_en.load_pen  = rdy[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    aop_axis #(.COORD_BITS(W)) u_axis_x (
        .i_clk      (i_clk),
        .i_en       (axis_en),
        .i_self_lo  (i_s_axis_tdata[0*W +: W]),
        .i_self_hi  (i_s_axis_tdata[1*W +: W]),
        .i_other_lo (i_s_axis_tdata[4*W +: W]),
        .i_other_hi (i_s_axis_tdata[5*W +: W]),
        .o_pen      (pen_x),
        .o_nrm      (nrm_x),
        .o_self_c   (sc_x),
        .o_self_h   (sh_x),
        .o_other_c  (oc_x)
    );

    aop_axis #(.COORD_BITS(W)) u_axis_y (
        .i_clk      (i_clk),
        .i_en       (axis_en),
        .i_self_lo  (i_s_axis_tdata[2*W +: W]),
        .i_self_hi  (i_s_axis_tdata[3*W +: W]),
        .i_other_lo (i_s_axis_tdata[6*W +: W]),
        .i_other_hi (i_s_axis_tdata[7*W +: W]),
        .o_pen      (pen_y),
        .o_nrm      (nrm_y),
        .o_self_c   (sc_y),
        .o_self_h   (sh_y),
        .o_other_c  (oc_y)
    );

    logic              hit, x_sel;
    logic signed [W:0] mag_x, mag_y, del_x, del_y, ctc_x, ctc_y;

    logic              n_hit;
    logic signed [W:0] n_del_x, n_del_y, n_pos_x, n_pos_y;
    logic        [1:0] n_nx, n_ny;

    logic              r_hit;
    logic signed [W:0] r_del_x, r_del_y, r_pos_x, r_pos_y;
    logic        [1:0] r_nx, r_ny;

    always_comb begin
        hit   = !pen_x[W+1] && (pen_x != '0) && !pen_y[W+1] && (pen_y != '0);
        x_sel = pen_x < pen_y;
        mag_x = pen_x[W:0];
        mag_y = pen_y[W:0];
        case (nrm_x)
            NRM_POS: begin
                del_x = mag_x;
                ctc_x = (W+1)'(sc_x) + (W+1)'(sh_x);
            end
            NRM_NEG: begin
                del_x = -mag_x;
                ctc_x = (W+1)'(sc_x) - (W+1)'(sh_x);
            end
            default: begin
                del_x = '0;
                ctc_x = (W+1)'(sc_x);
            end
        endcase
        case (nrm_y)
            NRM_POS: begin
                del_y = mag_y;
                ctc_y = (W+1)'(sc_y) + (W+1)'(sh_y);
            end
            NRM_NEG: begin
                del_y = -mag_y;
                ctc_y = (W+1)'(sc_y) - (W+1)'(sh_y);
            end
            default: begin
                del_y = '0;
                ctc_y = (W+1)'(sc_y);
            end
        endcase

        n_hit   = hit;
        n_del_x = '0;
        n_del_y = '0;
        n_nx    = NRM_ZERO;
        n_ny    = NRM_ZERO;
        n_pos_x = '0;
        n_pos_y = '0;
        if (hit && x_sel) begin
            n_del_x = del_x;
            n_nx    = nrm_x;
            n_pos_x = ctc_x;
            n_pos_y = (W+1)'(oc_y);
        end else if (hit) begin
            n_del_y = del_y;
            n_ny    = nrm_y;
            n_pos_x = (W+1)'(oc_x);
            n_pos_y = ctc_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[PIPE_STAGES-1]) begin
            r_hit   <= n_hit;
            r_del_x <= n_del_x;
            r_del_y <= n_del_y;
            r_nx    <= n_nx;
            r_ny    <= n_ny;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
        end
    end

    assign o_s_axis_tready = rdy[0];
    assign o_m_axis_tvalid = r_vld[PIPE_STAGES-1];

    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[OUT_USED-1:0] =
            {r_pos_y, r_pos_x, r_ny, r_nx, r_del_y, r_del_x, r_hit};
    end

endmodule

`default_nettype wire

// File: design/aop_axis.sv
`default_nettype none

module aop_axis import aop_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  t_axis_en                      i_en,
    input  logic signed [COORD_BITS-1:0]  i_self_lo,
    input  logic signed [COORD_BITS-1:0]  i_self_hi,
    input  logic signed [COORD_BITS-1:0]  i_other_lo,
    input  logic signed [COORD_BITS-1:0]  i_other_hi,
    output logic signed [COORD_BITS+1:0]  o_pen,
    output logic        [1:0]             o_nrm,
    output logic signed [COORD_BITS-1:0]  o_self_c,
    output logic signed [COORD_BITS-1:0]  o_self_h,
    output logic signed [COORD_BITS-1:0]  o_other_c
);

    localparam int W = COORD_BITS;

    function automatic logic signed [W-1:0] halve(input logic signed [W:0] v);
        logic [W:0] t;
        t = v + (W+1)'(v[W]);
        return t[W:1];
    endfunction

    logic signed [W:0]   r_self_sum, r_self_dif, r_oth_sum, r_oth_dif;
    logic signed [W-1:0] r1_sc, r1_sh, r1_oc, r1_oh;
    logic signed [W:0]   r2_d, r2_hs;
    logic signed [W-1:0] r2_sc, r2_sh, r2_oc;
    logic signed [W+1:0] r3_pen;
    logic        [1:0]   r3_nrm;
    logic signed [W-1:0] r3_sc, r3_sh, r3_oc;

    logic signed [W+1:0] n_pen;
    logic signed [W+1:0] d_ext;
    logic signed [W+1:0] d_abs;
    logic        [1:0]   n_nrm;

    always_ff @(posedge i_clk) begin
        if (i_en.load_sum) begin
            r_self_sum <= (W+1)'(i_self_hi) + (W+1)'(i_self_lo);
            r_self_dif <= (W+1)'(i_self_hi) - (W+1)'(i_self_lo);
            r_oth_sum  <= (W+1)'(i_other_hi) + (W+1)'(i_other_lo);
            r_oth_dif  <= (W+1)'(i_other_hi) - (W+1)'(i_other_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_half) begin
            r1_sc <= halve(r_self_sum);
            r1_sh <= halve(r_self_dif);
            r1_oc <= halve(r_oth_sum);
            r1_oh <= halve(r_oth_dif);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_diff) begin
            r2_d  <= (W+1)'(r1_oc) - (W+1)'(r1_sc);
            r2_hs <= (W+1)'(r1_oh) + (W+1)'(r1_sh);
            r2_sc <= r1_sc;
            r2_sh <= r1_sh;
            r2_oc <= r1_oc;
        end
    end

    always_comb begin
        d_ext = (W+2)'(r2_d);
        d_abs = r2_d[W] ? -d_ext : d_ext;
        n_pen = (W+2)'(r2_hs) - d_abs;
        if (r2_d[W]) begin
            n_nrm = NRM_NEG;
        end else if (r2_d != '0) begin
            n_nrm = NRM_POS;
        end else begin
            n_nrm = NRM_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_pen) begin
            r3_pen <= n_pen;
            r3_nrm <= n_nrm;
            r3_sc  <= r2_sc;
            r3_sh  <= r2_sh;
            r3_oc  <= r2_oc;
        end
    end

    assign o_pen     = r3_pen;
    assign o_nrm     = r3_nrm;
    assign o_self_c  = r3_sc;
    assign o_self_h  = r3_sh;
    assign o_other_c = r3_oc;

endmodule

`default_nettype wire

// File: design/aop_checker.sv
`default_nettype none

`include "aabb_overlap_penetration_assert.svh"

module aop_checker import aop_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic [((4*COORD_BITS+9+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int W      = COORD_BITS;
    localparam int OUT_W  = ((4*W+9+7)/8)*8;
    localparam int DY_LO  = W + 2;
    localparam int NX_LO  = 2*W + 3;
    localparam int NY_LO  = 2*W + 5;

    logic             hit;
    logic [W:0]       del_x, del_y;
    logic [1:0]       nx, ny;
    logic             out_vld, stall, miss, x_nrm, x_only;
    logic [OUT_W-1:0] out_data;
    logic [OUT_W-2:0] rest;

    assign hit      = o_m_axis_tdata[0];
    assign del_x    = o_m_axis_tdata[1 +: W+1];
    assign del_y    = o_m_axis_tdata[DY_LO +: W+1];
    assign nx       = o_m_axis_tdata[NX_LO +: 2];
    assign ny       = o_m_axis_tdata[NY_LO +: 2];
    assign out_vld  = o_m_axis_tvalid;
    assign out_data = o_m_axis_tdata;
    assign rest     = o_m_axis_tdata[OUT_W-1:1];
    assign stall    = o_m_axis_tvalid && !i_m_axis_tready;
    assign miss     = o_m_axis_tvalid && !hit;
    assign x_nrm    = o_m_axis_tvalid && nx != NRM_ZERO;
    assign x_only   = ny == NRM_ZERO && del_y == '0 && del_x != '0;

    `AOP_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, miss, rest == '0)
    `AOP_ASSERT_IMP(a_one_axis, i_clk, i_rst_n, out_vld, del_x == '0 || del_y == '0)
    `AOP_ASSERT_IMP(a_x_normal, i_clk, i_rst_n, x_nrm, x_only)
    `AOP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, stall, out_vld && $stable(out_data))

endmodule

bind aabb_overlap_penetration aop_checker #(.COORD_BITS(COORD_BITS)) u_aop_checker (.*);

`default_nettype wire
